// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication or expression on every clock edge out of reset.
`define BLSUP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define BLSUP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/blsup_pkg.sv =====
// Types, codes and constants of the broker link supervisor.
package blsup_pkg;

	localparam int unsigned CntW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CntW-1:0] LimForever = 8'hFF;
	localparam logic [CntW-1:0] MaxShift = 8'd3;
	localparam logic [CntW-1:0] ConnectWaitRst = 8'd10;
	localparam logic [CntW-1:0] ReconnectRst = 8'hFF;

	typedef enum logic [2:0] {
		ST_INIT       = 3'd0,
		ST_REG        = 3'd1,
		ST_CONNECTING = 3'd2,
		ST_CONNECTED  = 3'd3,
		ST_PUBLISHING = 3'd4,
		ST_DISC       = 3'd5,
		ST_ERROR      = 3'd6
	} link_state_t;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_UP   = 2'd1,
		FUNC_DOWN = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		LED_NONE       = 2'd0,
		LED_NO_NET     = 2'd1,
		LED_CONNECTING = 2'd2,
		LED_STEADY     = 2'd3
	} led_t;

	typedef enum logic [1:0] {
		RESCHED_NONE     = 2'd0,
		RESCHED_NET_WAIT = 2'd1,
		RESCHED_NORMAL   = 2'd2,
		RESCHED_BACKOFF  = 2'd3
	} resched_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CONNECT_WAIT = 2'd0,
		CFG_RECONNECT    = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] func;
		logic       has_global_addr;
		logic       link_ready;
		logic       stable_elapsed;
	} blsup_item_t;

	typedef struct packed {
		logic [2:0]      link_state;
		logic            do_register;
		logic            do_connect;
		logic            do_disconnect;
		logic            notify_up;
		logic            notify_down;
		logic            request_reset;
		logic            start_stable_timer;
		led_t            led_action;
		resched_t        reschedule;
		logic [1:0]      backoff_shift;
		logic [CntW-1:0] attempt_count;
	} blsup_result_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] idx;
		logic [CntW-1:0]    wdata;
	} blsup_cfg_t;

	typedef struct packed {
		logic [CntW-1:0] connect_wait_limit;
		logic [CntW-1:0] reconnect_limit;
	} blsup_limits_t;

endpackage

// ===== hdl/blsup_chan_if.sv =====
// Valid/ready channel carrying one payload item.
interface blsup_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/blsup_step.sv =====
// Next-state and result logic for one supervisor item.
module blsup_step import blsup_pkg::*; (
	input  blsup_item_t     item,
	input  link_state_t     state,
	input  logic [CntW-1:0] attempts,
	input  blsup_limits_t   limits,
	output link_state_t     state_nxt,
	output logic [CntW-1:0] attempts_nxt,
	output blsup_result_t   result
);

	logic [CntW-1:0] att_inc;
	logic            forever_retry;

	assign att_inc       = attempts + 8'd1;
	assign forever_retry = (limits.reconnect_limit == LimForever);

	always_comb begin
		state_nxt    = state;
		attempts_nxt = attempts;
		result       = '0;
		case (item.func)
			FUNC_TICK: begin
				case (state)
					ST_INIT, ST_REG: begin
						// init registers first, then takes the registered path
						if (state == ST_INIT) begin
							result.do_register = 1'b1;
							attempts_nxt = 8'd1;
						end
						if (item.has_global_addr) begin
							result.do_connect = 1'b1;
							attempts_nxt = '0;
							state_nxt = ST_CONNECTING;
						end else begin
							result.led_action = LED_NO_NET;
							state_nxt = ST_REG;
						end
						result.reschedule = RESCHED_NET_WAIT;
					end
					ST_CONNECTING: begin
						result.led_action = LED_CONNECTING;
						if (att_inc < limits.connect_wait_limit || forever_retry) begin
							attempts_nxt = att_inc;
							result.reschedule = RESCHED_NORMAL;
						end else begin
							// give up; the connected path runs with state disconnected
							attempts_nxt = '0;
							state_nxt = ST_DISC;
							result.reschedule = item.link_ready ? RESCHED_NONE : RESCHED_NORMAL;
						end
					end
					ST_CONNECTED, ST_PUBLISHING: begin
						if (state == ST_CONNECTED || item.stable_elapsed)
							attempts_nxt = '0;
						if (item.link_ready) begin
							if (state == ST_CONNECTED) begin
								result.notify_up = 1'b1;
								state_nxt = ST_PUBLISHING;
							end
							result.reschedule = RESCHED_NONE;
						end else begin
							result.reschedule = RESCHED_NORMAL;
						end
					end
					ST_DISC: begin
						result.notify_down = 1'b1;
						if (attempts < limits.reconnect_limit || forever_retry) begin
							result.do_disconnect = 1'b1;
							attempts_nxt = att_inc;
							result.backoff_shift = (att_inc > MaxShift) ? MaxShift[1:0]
								: att_inc[1:0];
							result.reschedule = RESCHED_BACKOFF;
							state_nxt = ST_REG;
						end else begin
							state_nxt = ST_ERROR;
							result.reschedule = RESCHED_NORMAL;
						end
					end
					default: begin
						// error and the unused code: hold state, ask for reset
						result.led_action = LED_STEADY;
						result.request_reset = 1'b1;
					end
				endcase
			end
			FUNC_UP: begin
				state_nxt = ST_CONNECTED;
				result.start_stable_timer = 1'b1;
			end
			FUNC_DOWN: begin
				state_nxt = ST_DISC;
			end
			default: begin
			end
		endcase
		result.link_state    = state_nxt;
		result.attempt_count = attempts_nxt;
	end

endmodule

// ===== hdl/broker_link_supervisor_core.sv =====
// Top level of the broker link supervisor: registers, handshakes and configuration.
//
//  channel | dir | payload        | handshake
//  --------+-----+----------------+---------------------------------
//  cfg     | in  | blsup_cfg_t    | valid/ready, ready always high
//  req     | in  | blsup_item_t   | valid/ready
//  rsp     | out | blsup_result_t | valid/ready, registered
//
//  An item waits in the input register and then sits in the result register; while
//  rsp does not stall, one item enters per cycle and one result leaves per cycle.
//  Link state and attempt counter update when the item leaves the input register.
//  A stall on rsp holds the result; the input register still takes one more item.
//  Reset restores init state, zero attempts and the default limits.
module broker_link_supervisor_core import blsup_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	blsup_chan_if.sink   cfg,
	blsup_chan_if.sink   req,
	blsup_chan_if.source rsp
);

	`include "assert_macros.svh"

	// input register
	blsup_item_t   item_s1;
	logic          v_s1_q;
	logic          adv;

	// result register
	blsup_result_t rsp_data_q;
	logic          rsp_v_q;

	// supervisor state and limits
	link_state_t     state_q;
	logic [CntW-1:0] attempts_q;
	blsup_limits_t   limits_q;

	link_state_t     state_nxt;
	logic [CntW-1:0] attempts_nxt;
	blsup_result_t   result;

	// Advance the input item whenever the result register is free or drains.
	assign adv       = v_s1_q && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1_q || adv;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_data_q;

	blsup_step u_step (
		.item         (item_s1),
		.state        (state_q),
		.attempts     (attempts_q),
		.limits       (limits_q),
		.state_nxt    (state_nxt),
		.attempts_nxt (attempts_nxt),
		.result       (result)
	);

	// Control: valid flags, state and limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q   <= 1'b0;
			rsp_v_q  <= 1'b0;
			state_q  <= ST_INIT;
			attempts_q <= '0;
			limits_q.connect_wait_limit <= ConnectWaitRst;
			limits_q.reconnect_limit    <= ReconnectRst;
		end else begin
			if (req.valid && req.ready)
				v_s1_q <= 1'b1;
			else if (adv)
				v_s1_q <= 1'b0;

			if (adv)
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;

			// commit the item's state update as it moves to the result register
			if (adv) begin
				state_q    <= state_nxt;
				attempts_q <= attempts_nxt;
			end

			// drop writes to indexes beyond the register list
			if (cfg.valid) begin
				case (cfg.data.idx)
					CFG_CONNECT_WAIT: limits_q.connect_wait_limit <= cfg.data.wdata;
					CFG_RECONNECT:    limits_q.reconnect_limit    <= cfg.data.wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// Payload: capture the item and the result, no reset needed.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.data;
		if (adv)
			rsp_data_q <= result;
	end

	`BLSUP_ASSERT(a_no_accept_when_full, (v_s1_q && !adv) |-> !req.ready, "input taken while input register stalled")
	`BLSUP_ASSERT_NEXT(a_adv_fills_rsp, adv, rsp_v_q, "advanced item missing from result register")
	`BLSUP_ASSERT(a_reset_in_error, (rsp_v_q && rsp_data_q.request_reset) |-> (rsp_data_q.link_state == ST_ERROR), "reset request outside error state")
	`BLSUP_ASSERT(a_connect_clears, (rsp_v_q && rsp_data_q.do_connect) |-> (rsp_data_q.link_state == ST_CONNECTING && rsp_data_q.attempt_count == 8'd0), "connect without cleared attempts")
	`BLSUP_ASSERT(a_shift_only_backoff, (rsp_v_q && rsp_data_q.backoff_shift != 2'd0) |-> (rsp_data_q.reschedule == RESCHED_BACKOFF), "backoff shift outside backoff reschedule")

endmodule

// ===== tb/sv/broker_link_checker.sv =====
// Checker for the broker link supervisor: tracks limits, predicts each result and compares.
module broker_link_checker import blsup_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  blsup_cfg_t    cfg_data,
	input  logic          req_valid,
	input  logic          req_ready,
	input  blsup_item_t   req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  blsup_result_t rsp_data,
	output int            fails,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CntW-1:0] wait_lim;
	logic [CntW-1:0] retry_lim;
	logic [CntW-1:0] attempts;
	logic [2:0]      link_st;
	blsup_result_t   awaited_results[$];

	// Advance the link state and attempt counter by one item and build its result.
	function automatic blsup_result_t supervise(blsup_item_t it);
		blsup_result_t r;
		logic [2:0]    s;
		r = '0;
		s = link_st;
		case (it.func)
			FUNC_TICK: begin
				if (s == ST_INIT) begin
					r.do_register = 1'b1;
					attempts = 8'd1;
					s = ST_REG;
				end
				if (s == ST_REG) begin
					if (it.has_global_addr) begin
						r.do_connect = 1'b1;
						attempts = '0;
						s = ST_CONNECTING;
					end else begin
						r.led_action = LED_NO_NET;
					end
					r.reschedule = RESCHED_NET_WAIT;
				end else if (s == ST_CONNECTING) begin
					r.led_action = LED_CONNECTING;
					attempts = attempts + 8'd1;
					if (attempts < wait_lim || retry_lim == LimForever) begin
						r.reschedule = RESCHED_NORMAL;
					end else begin
						// give up: drop to disconnected, then run the connected path
						attempts = '0;
						s = ST_DISC;
						r.reschedule = it.link_ready ? RESCHED_NONE : RESCHED_NORMAL;
					end
				end else if (s == ST_CONNECTED || s == ST_PUBLISHING) begin
					if (s == ST_CONNECTED || it.stable_elapsed)
						attempts = '0;
					if (it.link_ready) begin
						if (s == ST_CONNECTED) begin
							r.notify_up = 1'b1;
							s = ST_PUBLISHING;
						end
						r.reschedule = RESCHED_NONE;
					end else begin
						r.reschedule = RESCHED_NORMAL;
					end
				end else if (s == ST_DISC) begin
					r.notify_down = 1'b1;
					if (attempts < retry_lim || retry_lim == LimForever) begin
						r.do_disconnect = 1'b1;
						attempts = attempts + 8'd1;
						r.backoff_shift = (attempts < MaxShift) ? attempts[1:0] : MaxShift[1:0];
						r.reschedule = RESCHED_BACKOFF;
						s = ST_REG;
					end else begin
						s = ST_ERROR;
						r.reschedule = RESCHED_NORMAL;
					end
				end else begin
					r.led_action = LED_STEADY;
					r.request_reset = 1'b1;
				end
				link_st = s;
			end
			FUNC_UP: begin
				link_st = ST_CONNECTED;
				r.start_stable_timer = 1'b1;
			end
			FUNC_DOWN: link_st = ST_DISC;
			default: ;
		endcase
		r.link_state = link_st;
		r.attempt_count = attempts;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blsup_result_t want;
		if (!arst_n) begin
			wait_lim = ConnectWaitRst;
			retry_lim = ReconnectRst;
			attempts = '0;
			link_st = ST_INIT;
			awaited_results.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result arrived with no item outstanding");
					fails++;
				end else begin
					want = awaited_results.pop_front();
					check_field("link_state", want.link_state, rsp_data.link_state);
					check_field("do_register", want.do_register, rsp_data.do_register);
					check_field("do_connect", want.do_connect, rsp_data.do_connect);
					check_field("do_disconnect", want.do_disconnect, rsp_data.do_disconnect);
					check_field("notify_up", want.notify_up, rsp_data.notify_up);
					check_field("notify_down", want.notify_down, rsp_data.notify_down);
					check_field("request_reset", want.request_reset, rsp_data.request_reset);
					check_field("start_stable_timer", want.start_stable_timer,
						rsp_data.start_stable_timer);
					check_field("led_action", want.led_action, rsp_data.led_action);
					check_field("reschedule", want.reschedule, rsp_data.reschedule);
					check_field("backoff_shift", want.backoff_shift, rsp_data.backoff_shift);
					check_field("attempt_count", want.attempt_count, rsp_data.attempt_count);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.idx)
					CFG_CONNECT_WAIT: wait_lim = cfg_data.wdata;
					CFG_RECONNECT:    retry_lim = cfg_data.wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				awaited_results.push_back(supervise(req_data));
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/broker_link_supervisor_core_tb.sv =====
// Testbench top for the broker link supervisor: clock, reset, stimulus and verdict.
module broker_link_supervisor_core_tb;
	import blsup_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Limit = 400000;       // cycles before the run is declared hung
	localparam int LongHold = 300;       // receiver hold-off used to back the block up
	localparam int PhaseItems = 140;     // random items per limit setting
	localparam int NumPhases = 7;
	localparam logic [1:0] FuncUnused = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycle_cnt = 0;
	bit   sender_quiet = 1'b0;
	bit   receiver_quiet = 1'b0;
	bit   hold_off_req = 1'b0;

	blsup_chan_if #(.payload_t(blsup_cfg_t))    cfg_ch ();
	blsup_chan_if #(.payload_t(blsup_item_t))   req_ch ();
	blsup_chan_if #(.payload_t(blsup_result_t)) rsp_ch ();

	broker_link_supervisor_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	broker_link_checker link_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_ch.valid),
		.cfg_ready (cfg_ch.ready),
		.cfg_data  (cfg_ch.data),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_data  (req_ch.data),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_data  (rsp_ch.data),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic blsup_item_t mk(logic [1:0] f, logic g, logic r, logic s);
		blsup_item_t it;
		it.func = f;
		it.has_global_addr = g;
		it.link_ready = r;
		it.stable_elapsed = s;
		return it;
	endfunction

	// Random flags; favor a global address so registration usually moves on to connect.
	function automatic blsup_item_t rand_item(logic [1:0] f);
		return mk(f, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// Offer one item and hold it until accepted. Valid stays high into the next
	// item when there is no gap, so it is never lowered and raised in one step.
	task automatic offer(blsup_item_t it);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic tick_run(int n);
		repeat (n) offer(rand_item(FUNC_TICK));
	endtask

	// Stop offering, wait until every item has its result, then let the pipeline settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write both limits back to back; valid stays high across the two writes.
	task automatic write_limits(logic [CntW-1:0] w, logic [CntW-1:0] r);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{idx: CFG_CONNECT_WAIT, wdata: w};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.data <= '{idx: CFG_RECONNECT, wdata: r};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Result side: stall a random number of cycles per result, with quiet stretches,
	// and honor a one-off long hold-off when the stimulus asks for it.
	initial begin
		int stall;
		int served;
		served = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end
			stall = receiver_quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			served++;
			if (served % 40 == 0)
				receiver_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: end a hung run.
	initial begin
		while (cycle_cnt < Limit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		blsup_item_t     directed[$];
		logic [CntW-1:0] wait_set[NumPhases];
		logic [CntW-1:0] retry_set[NumPhases];
		int              sent;
		int              pick;
		int              k;

		// Limit settings per phase: reset values, a zero wait limit, no retries,
		// near-forever retries with the longest wait, small limits, forever, random.
		wait_set  = '{8'd10, 8'd0, 8'd1, 8'd255, 8'd3, 8'd255, 8'd0};
		retry_set = '{8'd255, 8'd3, 8'd0, 8'd254, 8'd2, 8'd255, 8'd0};

		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk with tight limits so timeout, backoff and error are all reached.
		write_limits(8'd2, 8'd1);
		directed = '{
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b0),   // init tick: register, then no-network blink
			mk(FUNC_TICK, 1'b0, 1'b1, 1'b1),   // still no address
			mk(FUNC_TICK, 1'b1, 1'b0, 1'b0),   // address present: connect
			mk(FUNC_TICK, 1'b1, 1'b0, 1'b0),   // connecting, below the wait limit
			mk(FUNC_TICK, 1'b0, 1'b1, 1'b1),   // wait limit hit: through connected path
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b0),   // disconnected: back off, shift 1
			mk(FUNC_TICK, 1'b1, 1'b0, 1'b0),   // reconnect
			mk(FUNC_UP, 1'b0, 1'b0, 1'b0),     // connected event starts stable timer
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b1),   // connected, not ready
			mk(FUNC_TICK, 1'b0, 1'b1, 1'b0),   // ready: notify up, go publishing
			mk(FUNC_TICK, 1'b1, 1'b1, 1'b1),   // publishing, stable elapsed
			mk(FUNC_DOWN, 1'b1, 1'b1, 1'b1),   // disconnected event
			mk(FUNC_TICK, 1'b1, 1'b1, 1'b1),   // retry allowed
			mk(FUNC_DOWN, 1'b0, 1'b0, 1'b0),
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b0),   // retries exhausted: error
			mk(FUNC_TICK, 1'b1, 1'b1, 1'b1),   // error: steady LED, request reset
			mk(FuncUnused, 1'b1, 1'b1, 1'b1),  // unused item kind changes nothing
			mk(FUNC_UP, 1'b1, 1'b1, 1'b1),     // leave error through a connected event
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b0),
			mk(FUNC_DOWN, 1'b0, 1'b1, 1'b0),
			mk(FUNC_TICK, 1'b0, 1'b0, 1'b0)
		};
		foreach (directed[i])
			offer(directed[i]);

		for (int p = 0; p < NumPhases; p++) begin
			drain();
			if (p == NumPhases - 1) begin
				wait_set[p] = CntW'($urandom_range(0, 255));
				retry_set[p] = CntW'($urandom_range(0, 255));
			end
			write_limits(wait_set[p], retry_set[p]);

			// Back the block up once: long receiver hold while items keep coming.
			if (p == 2) begin
				hold_off_req = 1'b1;
				sender_quiet = 1'b1;
			end

			// With the longest wait, stay in connecting long enough to time out or wrap.
			if (wait_set[p] == 8'd255) begin
				offer(mk(FUNC_TICK, 1'b1, 1'b0, 1'b0));
				tick_run(262);
			end

			sent = 0;
			while (sent < PhaseItems) begin
				if ($urandom_range(0, 5) == 0)
					sender_quiet = !sender_quiet;
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					// burst of ticks around the connect-wait limit
					k = $urandom_range(1, (wait_set[p] < 37) ? wait_set[p] + 3 : 40);
					tick_run(k);
					sent += k;
				end else if (pick < 7) begin
					// session: register and connect, run, drop, recover
					k = $urandom_range(1, 3);
					tick_run(k);
					sent += k;
					if ($urandom_range(0, 4) != 0) begin
						offer(rand_item(FUNC_UP));
						sent++;
					end
					k = $urandom_range(1, 6);
					tick_run(k);
					sent += k;
					offer(rand_item(FUNC_DOWN));
					sent++;
					k = $urandom_range(1, 3);
					tick_run(k);
					sent += k;
				end else begin
					// noise: any item kind, unused code included
					offer(rand_item(2'($urandom_range(0, 3))));
					sent++;
				end
			end
		end

		drain();
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
